// File: hdl/yrgb_pkg.sv
// Package for the pixel-pair YUV to RGB converter.
// Holds the transaction payload structs, the chroma term and RGB structs,
// the fixed-point coefficients and the channel constants. Depends on nothing.
package yrgb_pkg;

    // Width of the intermediate fixed-point sums (luma * 256 plus chroma term).
    localparam int unsigned SUM_W = 18;

    // BT.601 style coefficients in 8-bit fixed point (scaled by 256).
    localparam logic signed [SUM_W-1:0] COEF_RED_V   = 18'sd358;
    localparam logic signed [SUM_W-1:0] COEF_GREEN_U = 18'sd88;
    localparam logic signed [SUM_W-1:0] COEF_GREEN_V = 18'sd182;
    localparam logic signed [SUM_W-1:0] COEF_BLUE_U  = 18'sd453;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_NONE   = 8'h00;
    localparam logic [7:0] CHAN_MAX     = 8'hFF;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic [7:0] prior_luma_first;
        logic [7:0] prior_luma_second;
        logic [7:0] prior_chroma_blue;
        logic [7:0] prior_chroma_red;
    } t_pair_in;

    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic       write_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic       write_second;
        logic [7:0] alpha_out;
    } t_pair_out;

    // Chroma contributions shared by both pixels of a pair.
    typedef struct packed {
        logic signed [SUM_W-1:0] red_term;
        logic signed [SUM_W-1:0] green_term;
        logic signed [SUM_W-1:0] blue_term;
    } t_chroma_terms;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

endpackage

// File: hdl/yrgb_chroma_terms.sv
// Chroma product terms for one pixel pair.
// Depends on yrgb_pkg.
module yrgb_chroma_terms (
    input  logic [7:0]                   i_chroma_blue,
    input  logic [7:0]                   i_chroma_red,
    output yrgb_pkg::t_chroma_terms      o_terms
);
    import yrgb_pkg::*;

    logic signed [7:0]       u_off;
    logic signed [7:0]       v_off;
    logic signed [SUM_W-1:0] u_ext;
    logic signed [SUM_W-1:0] v_ext;

    // Offset binary to two's complement: flipping the top bit subtracts 128.
    assign u_off = signed'({~i_chroma_blue[7], i_chroma_blue[6:0]});
    assign v_off = signed'({~i_chroma_red[7], i_chroma_red[6:0]});
    assign u_ext = SUM_W'(u_off);
    assign v_ext = SUM_W'(v_off);

    assign o_terms.red_term   = v_ext * COEF_RED_V;
    assign o_terms.green_term = -((u_ext * COEF_GREEN_U) + (v_ext * COEF_GREEN_V));
    assign o_terms.blue_term  = u_ext * COEF_BLUE_U;

endmodule

// File: hdl/yrgb_pixel.sv
// Converts one pixel: adds scaled luma to the chroma terms, floors, clamps
// and blanks the pixel when it is not written. Depends on yrgb_pkg.
module yrgb_pixel (
    input  logic [7:0]              i_luma,
    input  logic                    i_write,
    input  yrgb_pkg::t_chroma_terms i_terms,
    output yrgb_pkg::t_rgb          o_rgb
);
    import yrgb_pkg::*;

    logic signed [SUM_W-1:0] luma_scaled;
    logic signed [SUM_W-1:0] sum_red;
    logic signed [SUM_W-1:0] sum_green;
    logic signed [SUM_W-1:0] sum_blue;

    // Arithmetic shift right by 8, then clamp to 0..255.
    function automatic logic [7:0] clamp_chan(input logic signed [SUM_W-1:0] sum);
        logic [7:0] res;
        if (sum[SUM_W-1]) begin
            res = 8'h00;
        end else if (sum[SUM_W-2]) begin
            res = CHAN_MAX;
        end else begin
            res = sum[15:8];
        end
        return res;
    endfunction

    assign luma_scaled = signed'({2'b00, i_luma, 8'h00});
    assign sum_red     = luma_scaled + i_terms.red_term;
    assign sum_green   = luma_scaled + i_terms.green_term;
    assign sum_blue    = luma_scaled + i_terms.blue_term;

    always_comb begin
        if (i_write) begin
            o_rgb.red   = clamp_chan(sum_red);
            o_rgb.green = clamp_chan(sum_green);
            o_rgb.blue  = clamp_chan(sum_blue);
        end else begin
            o_rgb = '0;
        end
    end

endmodule

// File: hdl/yuv_to_rgb_pixel_pair_delta_core.sv
// Pixel-pair YUV to RGB converter with previous-frame change detection.
// An accepted input transaction passes the input register, then the result
// register, before its result is valid. Throughput: one pixel pair per cycle, set by the single
// combinational pass between the two registers; stalls only on output backpressure.
// Reset (i_rst_n, synchronous, active low) empties both stages; no other state.
// Depends on yrgb_pkg, yrgb_chroma_terms and yrgb_pixel.
module yuv_to_rgb_pixel_pair_delta_core #(
    parameter bit WITH_ALPHA = 1'b1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  yrgb_pkg::t_pair_in  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output yrgb_pkg::t_pair_out o_data
);
    import yrgb_pkg::*;

    // Input stage: holds the accepted transaction while the math runs.
    logic      r_in_valid;
    t_pair_in  r_in;

    // Result stage: the finished pixel pair waiting for the consumer.
    logic      r_out_valid;
    t_pair_out r_out;
    t_pair_out n_out;

    logic          out_advance;
    logic          same_chroma;
    logic          write_first;
    logic          write_second;
    t_chroma_terms terms;
    t_rgb          rgb_first;
    t_rgb          rgb_second;

    // The result stage can load whenever it is empty or being drained this
    // cycle. The input stage can load whenever its content moves on, so a
    // new transaction is taken every cycle while the output keeps flowing.
    assign out_advance = !r_out_valid || i_ready;
    assign o_ready     = !r_in_valid || out_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (out_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_data;
        end
        if (r_in_valid && out_advance) begin
            r_out <= n_out;
        end
    end

    // A pixel is skipped only when the shared chroma and its own luma both
    // match the previous frame; any chroma change rewrites both pixels.
    assign same_chroma  = (r_in.chroma_blue == r_in.prior_chroma_blue)
                       && (r_in.chroma_red == r_in.prior_chroma_red);
    assign write_first  = !(same_chroma && (r_in.luma_first == r_in.prior_luma_first));
    assign write_second = !(same_chroma && (r_in.luma_second == r_in.prior_luma_second));

    // The chroma products are shared by both pixels of the pair.
    yrgb_chroma_terms u_chroma_terms (
        .i_chroma_blue (r_in.chroma_blue),
        .i_chroma_red  (r_in.chroma_red),
        .o_terms       (terms)
    );

    yrgb_pixel u_pixel_first (
        .i_luma  (r_in.luma_first),
        .i_write (write_first),
        .i_terms (terms),
        .o_rgb   (rgb_first)
    );

    yrgb_pixel u_pixel_second (
        .i_luma  (r_in.luma_second),
        .i_write (write_second),
        .i_terms (terms),
        .o_rgb   (rgb_second)
    );

    always_comb begin
        n_out.red_first    = rgb_first.red;
        n_out.green_first  = rgb_first.green;
        n_out.blue_first   = rgb_first.blue;
        n_out.write_first  = write_first;
        n_out.red_second   = rgb_second.red;
        n_out.green_second = rgb_second.green;
        n_out.blue_second  = rgb_second.blue;
        n_out.write_second = write_second;
        n_out.alpha_out    = WITH_ALPHA ? ALPHA_OPAQUE : ALPHA_NONE;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef NO_ASSERTIONS
    // A loaded input stage moves into the result stage when it may advance.
    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_advance) |=> o_valid)
        else $error("input stage content did not reach the result stage");

    // Unwritten pixels carry zero color.
    a_blank_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.write_first) |->
            (o_data.red_first == 8'h00 && o_data.green_first == 8'h00
             && o_data.blue_first == 8'h00))
        else $error("unwritten even pixel has nonzero color");

    a_blank_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.write_second) |->
            (o_data.red_second == 8'h00 && o_data.green_second == 8'h00
             && o_data.blue_second == 8'h00))
        else $error("unwritten odd pixel has nonzero color");

    // A chroma change between frames forces both pixels to be written.
    a_chroma_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !same_chroma) |-> (write_first && write_second))
        else $error("chroma change did not rewrite both pixels");
`endif

endmodule
